>>> src/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants
// Word width, command codes and sequencer states of the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WordBits = 64;
  localparam int CntBits  = $clog2(WordBits + 1);

  typedef logic [WordBits-1:0] word_t;
  typedef logic [CntBits-1:0]  cnt_t;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_COMBINE,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_QN,
    ST_QD,
    ST_OUT
  } state_t;

  // Request into the shared iterative datapath.
  typedef struct packed {
    logic  mul;   // 1 multiply, 0 divide
    word_t a;
    word_t b;
  } op_req_t;

  // Answer of the shared datapath.
  typedef struct packed {
    word_t lo;    // product or quotient
    word_t hi;    // remainder
  } op_rsp_t;

endpackage

>>> src/rau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if: beat channels
// Valid/ready channels carrying operand beats and result beats.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        reduce;
  logic signed [63:0] a_num;
  logic signed [63:0] a_den;
  logic signed [63:0] b_num;
  logic signed [63:0] b_den;
  modport source (output valid, command, reduce, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, command, reduce, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] res_num;
  logic signed [63:0] res_den;
  logic        zero_gcd;
  modport source (output valid, res_num, res_den, zero_gcd, input ready);
  modport sink (input valid, res_num, res_den, zero_gcd, output ready);
endinterface

>>> src/rau_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_alu: shared iterative multiply / divide unit
// Shift-add multiply (low word) or signed truncated restoring divide, one
// bit per cycle.
// ----------------------------------------------------------------------------
module rau_alu (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rau_pkg::op_req_t req,
  output logic             done,
  output rau_pkg::op_rsp_t rsp
);
  import rau_pkg::*;

  logic  busy;
  logic  mul;
  cnt_t  cnt;
  word_t acc;     // product or remainder
  word_t sh;      // multiplicand or dividend/quotient
  word_t opb;     // multiplier or divisor magnitude
  logic  neg_q;
  logic  neg_r;
  logic [WordBits:0] trial;
  word_t ma;
  word_t mb;

  assign ma    = req.a[WordBits-1] ? (~req.a + 1'b1) : req.a;
  assign mb    = req.b[WordBits-1] ? (~req.b + 1'b1) : req.b;
  assign trial = {acc, sh[WordBits-1]} - {1'b0, opb};

  // A start request is only taken while the unit is idle.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (busy) begin
      if (cnt == cnt_t'(WordBits)) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (!mul) begin
          sh  <= neg_q ? (~sh + 1'b1) : sh;
          acc <= neg_r ? (~acc + 1'b1) : acc;
        end
      end else begin
        cnt <= cnt + 1'b1;
        if (mul) begin
          if (opb[0]) acc <= acc + sh;
          sh  <= sh << 1;
          opb <= opb >> 1;
        end else if (!trial[WordBits]) begin
          acc <= trial[WordBits-1:0];
          sh  <= {sh[WordBits-2:0], 1'b1};
        end else begin
          acc <= {acc[WordBits-2:0], sh[WordBits-1]};
          sh  <= {sh[WordBits-2:0], 1'b0};
        end
      end
    end else if (start) begin
      busy  <= 1'b1;
      mul   <= req.mul;
      cnt   <= '0;
      acc   <= '0;
      sh    <= req.mul ? req.a : ma;
      opb   <= req.mul ? req.b : mb;
      neg_q <= req.a[WordBits-1] ^ req.b[WordBits-1];
      neg_r <= req.a[WordBits-1];
    end
  end

  assign rsp.lo = mul ? acc : sh;
  assign rsp.hi = acc;

endmodule

>>> src/rational_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit: fraction add/sub/mul/div with optional gcd reduction
// Top level: sequencer around one shared iterative multiply/divide unit.
// ----------------------------------------------------------------------------
// Each beat takes two signed 64-bit fractions and a command. A single
// bit-serial unit does every multiply and every truncated divide. Add or
// subtract with equal denominators needs no products; otherwise three
// products are formed (two for multiply and divide). With reduce set, each
// Euclid gcd step is one check state plus one divide, and two more divides
// produce the reduced words. The unit holds one item at a time: in.ready
// is high only while idle, and the result beat waits in its register until
// taken. A gcd of zero (only for 0/0) returns the result unreduced with
// zero_gcd set.
module rational_arith_unit (
  input  logic       clk,
  input  logic       rst,
  rau_in_if.sink     in,
  rau_out_if.source  out
);
  import rau_pkg::*;

  state_t  state, state_next;
  cmd_t    cmd;
  logic    red;
  word_t   an, ad, bn, bd;
  word_t   num, den, x, y, t1;
  logic    zg;
  logic    start;
  op_req_t req;
  logic    done;
  op_rsp_t rsp;

  rau_alu u_alu (.clk, .rst, .start, .req, .done, .rsp);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    start      = 1'b0;
    req        = '0;
    case (state)
      ST_IDLE: begin
        if (in.valid) begin
          state_next = ST_COMBINE;
          if (!(in.command[1] == 1'b0 && in.a_den == in.b_den)) begin
            state_next = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: begin
        start = !done;
        req   = '{mul: 1'b1, a: an, b: (cmd == CMD_MUL) ? bn : bd};
        if (done) state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        start = !done;
        req   = '{mul: 1'b1, a: ad, b: (cmd == CMD_DIV) ? bn : bd};
        if (done) state_next = (cmd == CMD_MUL || cmd == CMD_DIV) ? ST_COMBINE : ST_MUL_C;
      end
      ST_MUL_C: begin
        start = !done;
        req   = '{mul: 1'b1, a: bn, b: ad};
        if (done) state_next = ST_COMBINE;
      end
      ST_COMBINE: state_next = red ? ST_GCD_CHK : ST_OUT;
      ST_GCD_CHK: state_next = (x == '0) ? ((y == '0) ? ST_OUT : ST_QN) : ST_GCD_DIV;
      ST_GCD_DIV: begin
        start = !done;
        req   = '{mul: 1'b0, a: y, b: x};
        if (done) state_next = ST_GCD_CHK;
      end
      ST_QN: begin
        start = !done;
        req   = '{mul: 1'b0, a: num, b: y};
        if (done) state_next = ST_QD;
      end
      ST_QD: begin
        start = !done;
        req   = '{mul: 1'b0, a: den, b: y};
        if (done) state_next = ST_OUT;
      end
      ST_OUT: if (out.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Operand, product and gcd registers; payload, so no reset.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd <= cmd_t'(in.command);
        red <= in.reduce;
        an  <= in.a_num;
        ad  <= in.a_den;
        bn  <= in.b_num;
        bd  <= in.b_den;
        zg  <= 1'b0;
        t1  <= '0;
        // Equal-denominator shortcut, used only by add and subtract.
        num <= (in.command == CMD_ADD) ? in.a_num + in.b_num : in.a_num - in.b_num;
        den <= in.a_den;
      end
      ST_MUL_A: if (done) t1 <= rsp.lo;
      ST_MUL_B: if (done) begin
        den <= rsp.lo;
        num <= t1;
      end
      ST_MUL_C: if (done) num <= (cmd == CMD_ADD) ? t1 + rsp.lo : t1 - rsp.lo;
      ST_COMBINE: begin
        x <= num;
        y <= den;
      end
      ST_GCD_CHK: if (x == '0 && y == '0) zg <= 1'b1;
      ST_GCD_DIV: if (done) begin
        y <= x;
        x <= rsp.hi;
      end
      ST_QN: if (done) num <= rsp.lo;
      ST_QD: if (done) den <= rsp.lo;
      default: ;
    endcase
  end

  assign in.ready     = (state == ST_IDLE);
  assign out.valid    = (state == ST_OUT);
  assign out.res_num  = num;
  assign out.res_den  = den;
  assign out.zero_gcd = zg;

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in.ready && out.valid))
    else $error("input and output open together");
  a_zg_red: assert property (@(posedge clk) disable iff (rst) (out.valid && out.zero_gcd) |-> red)
    else $error("zero gcd flag without reduce");
  a_zg_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.zero_gcd) |-> (num == '0 && den == '0))
    else $error("zero gcd flag on nonzero result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> (out.valid && $stable(num) && $stable(den)))
    else $error("result changed while stalled");

endmodule

>>> tb/tb_rational_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arith_unit: self-checking bench for the rational unit
// Drives fraction beats with random idling on both channels, predicts each
// result with a local model of the arithmetic and gcd reduction, and checks
// every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_rational_arith_unit;
  import rau_pkg::*;

  // One expected result beat.
  typedef struct {
    logic [63:0] num;
    logic [63:0] den;
    logic        zg;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arith_unit i_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  frac_res_t   pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned result_cnt = 0;

  // The period is 12 ns.
  initial begin
    forever #6 clk = ~clk;
  end

  // Every input is known from time zero.
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.reduce  = 1'b0;
    in_ch.a_num   = '0;
    in_ch.a_den   = '0;
    in_ch.b_num   = '0;
    in_ch.b_den   = '0;
    out_ch.ready  = 1'b0;
  end

  // Truncated signed remainder; the result takes the sign of the dividend.
  function automatic logic [63:0] trunc_rem(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, r;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    r  = ma % mb;
    return a[63] ? -r : r;
  endfunction

  // Truncated signed quotient; the most negative over minus one wraps.
  function automatic logic [63:0] trunc_div(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // Predicts one result beat from the operands of an accepted beat.
  function automatic frac_res_t fraction_result(cmd_t cmd, logic red,
      logic [63:0] an, logic [63:0] ad, logic [63:0] bn, logic [63:0] bd);
    frac_res_t   res;
    logic [63:0] num, den, x, y, r;
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        // Equal denominators skip the cross-multiplication.
        if (ad == bd) begin
          num = (cmd == CMD_ADD) ? an + bn : an - bn;
          den = ad;
        end else begin
          num = (cmd == CMD_ADD) ? an * bd + bn * ad : an * bd - bn * ad;
          den = ad * bd;
        end
      end
      CMD_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    res.zg = 1'b0;
    if (red) begin
      // Euclid with a truncated remainder, so the gcd can come out negative.
      x = num;
      y = den;
      while (x != 0) begin
        r = trunc_rem(y, x);
        y = x;
        x = r;
      end
      if (y == 0) begin
        res.zg = 1'b1;
      end else begin
        num = trunc_div(num, y);
        den = trunc_div(den, y);
      end
    end
    res.num = num;
    res.den = den;
    return res;
  endfunction

  // Random 64-bit word biased toward small magnitudes and edge values, so
  // gcd reductions and the wrap cases are hit often.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 64'($signed($urandom_range(0, 40)) - 20);
      4:          return {$urandom(), $urandom()};
      5:          return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom()};
      6:          return 64'h8000_0000_0000_0000;
      7:          return 64'h7FFF_FFFF_FFFF_FFFF;
      8:          return 64'($signed($urandom_range(0, 2000)) - 1000) * 64'd12;
      default:    return 64'(-1);
    endcase
  endfunction

  // Sends one beat, idling first with the current probability. The block is
  // busy after an accepted beat, so the sender drops valid and steps past
  // the acceptance before it may drive the next beat.
  task automatic send_fraction(cmd_t cmd, logic red, logic [63:0] an,
      logic [63:0] ad, logic [63:0] bn, logic [63:0] bd);
    while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.reduce  <= red;
    in_ch.a_num   <= an;
    in_ch.a_den   <= ad;
    in_ch.b_num   <= bn;
    in_ch.b_den   <= bd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(fraction_result(cmd, red, an, ad, bn, bd));
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver stalling, redrawn each cycle.
  always @(posedge clk) begin
    if (!rst) begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Checks every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    frac_res_t exp_res;
    if (!rst && out_ch.valid && out_ch.ready) begin
      result_cnt <= result_cnt + 1;
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        err_cnt <= err_cnt + 1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.res_num !== exp_res.num) begin
          $error("res_num: expected %0d, got %0d", $signed(exp_res.num), out_ch.res_num);
          err_cnt <= err_cnt + 1;
        end
        if (out_ch.res_den !== exp_res.den) begin
          $error("res_den: expected %0d, got %0d", $signed(exp_res.den), out_ch.res_den);
          err_cnt <= err_cnt + 1;
        end
        if (out_ch.zero_gcd !== exp_res.zg) begin
          $error("zero_gcd: expected %0b, got %0b", exp_res.zg, out_ch.zero_gcd);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  // Watchdog: ends the simulation as failed if the run overruns the cycle limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 12_000_000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Holds the sender until every expected result has come.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Extremes of the operand words, every command, both reduce settings, the
  // equal-denominator shortcut, 0/0, zero denominators and the wrap of the
  // most negative value over minus one.
  task automatic test_directed();
    logic [63:0] mn, mx, m1;
    mn = 64'h8000_0000_0000_0000;
    mx = 64'h7FFF_FFFF_FFFF_FFFF;
    m1 = 64'(-1);
    send_fraction(CMD_ADD, 1'b1, 64'd1, 64'd4, 64'd1, 64'd4);
    send_fraction(CMD_SUB, 1'b1, 64'd3, 64'd6, 64'd1, 64'd6);
    send_fraction(CMD_ADD, 1'b1, 64'd1, 64'd2, 64'd1, 64'd3);
    send_fraction(CMD_SUB, 1'b0, 64'd1, 64'd2, 64'd1, 64'd3);
    send_fraction(CMD_MUL, 1'b1, 64'd2, 64'd3, 64'd9, 64'd4);
    send_fraction(CMD_DIV, 1'b1, 64'd2, 64'd3, 64'd4, 64'd9);
    send_fraction(CMD_DIV, 1'b0, m1, 64'd7, 64'd5, m1);
    // A 0/0 result with reduce set raises the flag.
    send_fraction(CMD_MUL, 1'b1, 64'd0, 64'd0, 64'd5, 64'd3);
    send_fraction(CMD_ADD, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0);
    send_fraction(CMD_MUL, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0);
    // Zero denominators reduce to 1/0, the gcd being the numerator itself.
    send_fraction(CMD_ADD, 1'b1, 64'd5, 64'd0, 64'd3, 64'd0);
    send_fraction(CMD_SUB, 1'b1, 64'd5, 64'd0, 64'd3, 64'd2);
    // Most negative over minus one.
    send_fraction(CMD_MUL, 1'b1, mn, m1, 64'd1, 64'd1);
    send_fraction(CMD_DIV, 1'b1, mn, 64'd1, m1, 64'd1);
    send_fraction(CMD_ADD, 1'b1, mx, mx, mx, mx);
    send_fraction(CMD_SUB, 1'b1, mn, mn, mx, mx);
    send_fraction(CMD_MUL, 1'b1, mx, mn, mn, mx);
    send_fraction(CMD_DIV, 1'b1, m1, m1, m1, m1);
    send_fraction(CMD_ADD, 1'b0, mx, mn, m1, mx);
    send_fraction(CMD_SUB, 1'b1, m1, 64'd6, 64'd4, 64'd6);
    send_fraction(CMD_MUL, 1'b1, 64'd6, 64'd10, m1, 64'd3);
    wait_drained();
  endtask

  // Random items under one setting of sender idling and receiver stalling.
  task automatic test_random(int unsigned n_items, int unsigned idle_pct,
      int unsigned stall_pct);
    logic [63:0] ad;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      ad = rand_word();
      // Some add/sub beats share a denominator to take the shortcut.
      send_fraction(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 3) != 0),
        rand_word(), ad, rand_word(), ($urandom_range(0, 3) == 0) ? ad : rand_word());
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(270, 0, 0);
    test_random(270, 51, 0);
    test_random(270, 0, 51);
    test_random(270, 22, 22);
    // Let the block settle before the verdict.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/rau_pkg.sv
src/rau_if.sv
src/rau_alu.sv
src/rational_arith_unit.sv
tb/tb_rational_arith_unit.sv
